// File: rtl/sitd_pkg.sv
package sitd_pkg;

  localparam int DEF_DATA_WIDTH = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CHAR_WIDTH     = 8;

  localparam logic [CHAR_WIDTH-1:0] CHR_MINUS = 8'd45;
  localparam logic [CHAR_WIDTH-1:0] CHR_ZERO  = 8'd48;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  // decimal digits needed for a magnitude up to 2^(width-1)
  // (77/256 is just below log10(2))
  function automatic int num_digits(input int width);
    return (width * 77) / 256 + 1;
  endfunction

endpackage

// File: rtl/sitd_front.sv
module sitd_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  value_valid,
  output logic                  value_ready,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic                  push_neg,
  output logic [DATA_WIDTH-1:0] push_mag
);
  import sitd_pkg::*;

  logic                  hold_valid;
  logic                  hold_neg;
  logic [DATA_WIDTH-1:0] hold_mag;
  logic                  in_neg;

  assign in_neg      = value[DATA_WIDTH-1];
  assign value_ready = !hold_valid || push_ready;
  assign push_valid  = hold_valid;
  assign push_neg    = hold_neg;
  assign push_mag    = hold_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (value_ready) begin
      hold_valid <= value_valid;
    end
  end

  // sign split and magnitude; the most negative value wraps to 2^(w-1) unsigned
  always_ff @(posedge clk) begin
    if (value_ready && value_valid) begin
      hold_neg <= in_neg;
      hold_mag <= in_neg ? (~value + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : value;
    end
  end

endmodule

// File: rtl/sitd_fifo.sv
module sitd_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import sitd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/sitd_back.sv
module sitd_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  logic                              pop_neg,
  input  logic [DATA_WIDTH-1:0]             pop_mag,
  output logic                              char_valid,
  input  logic                              char_ready,
  output logic [sitd_pkg::CHAR_WIDTH-1:0]   character,
  output logic                              last
);
  import sitd_pkg::*;

  localparam int NDIG = num_digits(DATA_WIDTH);
  localparam int BW   = NDIG * 4;
  localparam int CW   = $clog2(DATA_WIDTH + 1);
  localparam int DW   = $clog2(NDIG + 1);

  state_t                state;
  state_t                state_next;
  logic [DATA_WIDTH-1:0] mag_sh;
  logic [DATA_WIDTH-1:0] mag_sh_next;
  logic [BW-1:0]         bcd;
  logic [BW-1:0]         bcd_next;
  logic [BW-1:0]         bcd_adj;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [DW-1:0]         dcnt;
  logic [DW-1:0]         dcnt_next;
  logic                  neg;
  logic                  neg_next;
  logic                  started;
  logic                  started_next;
  logic                  out_load;
  logic [CHAR_WIDTH-1:0] out_char;
  logic                  out_last;
  logic                  can_load;
  logic [3:0]            top_digit;
  logic                  emit;

  assign can_load  = !char_valid || char_ready;
  assign top_digit = bcd[BW-1 -: 4];
  assign emit      = started || (top_digit != 4'd0) || (dcnt == DW'(1));

  // add-3 correction on every digit before each shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mag_sh  <= mag_sh_next;
    bcd     <= bcd_next;
    cnt     <= cnt_next;
    dcnt    <= dcnt_next;
    neg     <= neg_next;
    started <= started_next;
  end

  always_comb begin
    state_next   = state;
    mag_sh_next  = mag_sh;
    bcd_next     = bcd;
    cnt_next     = cnt;
    dcnt_next    = dcnt;
    neg_next     = neg;
    started_next = started;
    pop_ready    = 1'b0;
    out_load     = 1'b0;
    out_char     = CHR_ZERO;
    out_last     = 1'b0;
    case (state)
      ST_IDLE: begin
        pop_ready    = 1'b1;
        mag_sh_next  = pop_mag;
        neg_next     = pop_neg;
        bcd_next     = '0;
        cnt_next     = CW'(DATA_WIDTH);
        started_next = 1'b0;
        if (pop_valid) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_next    = {bcd_adj[BW-2:0], mag_sh[DATA_WIDTH-1]};
        mag_sh_next = {mag_sh[DATA_WIDTH-2:0], 1'b0};
        cnt_next    = cnt - 1'b1;
        dcnt_next   = DW'(NDIG);
        if (cnt == CW'(1)) begin
          state_next = neg ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (can_load) begin
          out_load   = 1'b1;
          out_char   = CHR_MINUS;
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (!emit || can_load) begin
          out_load     = emit;
          out_char     = CHR_ZERO + {4'd0, top_digit};
          out_last     = (dcnt == DW'(1));
          bcd_next     = {bcd[BW-5:0], 4'd0};
          dcnt_next    = dcnt - 1'b1;
          started_next = emit;
          if (dcnt == DW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (can_load) begin
      char_valid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      character <= out_char;
      last      <= out_last;
    end
  end

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
// signed_int_to_decimal_ascii: signed binary integer to decimal ascii text
//
// input channel (value_valid / value_ready / value): one beat per integer,
//   DATA_WIDTH bits, two's complement
// output channel (char_valid / char_ready / character / last): one beat per
//   ascii character, '-' first for a negative value, then the digits most
//   significant first with no leading zeros; last marks the final digit
// front end splits sign and magnitude and drops them into a two-entry queue,
//   so the input keeps taking beats while the back end converts
// back end: bit-serial double dabble, one shift per cycle over DATA_WIDTH
//   bits, then a digit sweep over each decimal position
//   (num_digits positions, 10 at 32 bits), plus a sign step for a negative
//   value and an idle step to pick up the next item
// the back end takes a new integer only once the last digit of the previous
//   one has left the sweep; the shift loop and digit sweep set the pace
// first character: front register, queue, idle pick-up, shift loop, then
//   output register (sign or full-length number); a skipped zero adds a step
// reset: queue, sequencer and output register empty; no state across items
// stall: a held output beat stalls the digit sweep, then the queue fills,
//   then value_ready drops
module signed_int_to_decimal_ascii #(
  parameter int DATA_WIDTH = sitd_pkg::DEF_DATA_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            value_valid,
  output logic                            value_ready,
  input  logic [DATA_WIDTH-1:0]           value,
  output logic                            char_valid,
  input  logic                            char_ready,
  output logic [sitd_pkg::CHAR_WIDTH-1:0] character,
  output logic                            last
);
  import sitd_pkg::*;

  // queue entry: {sign, magnitude}
  localparam int QW = DATA_WIDTH + 1;

  logic                  push_valid;
  logic                  push_ready;
  logic                  push_neg;
  logic [DATA_WIDTH-1:0] push_mag;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [QW-1:0]         pop_data;

  // sign / magnitude split
  sitd_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_neg    (push_neg),
    .push_mag    (push_mag)
  );

  // decouples the front from the slow back end
  sitd_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_neg, push_mag}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // double dabble and character emission
  sitd_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_neg    (pop_data[QW-1]),
    .pop_mag    (pop_data[DATA_WIDTH-1:0]),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .character  (character),
    .last       (last)
  );

endmodule

// File: rtl/sitd_checker.sv
module sitd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            char_valid,
  input logic                            char_ready,
  input logic [sitd_pkg::CHAR_WIDTH-1:0] character,
  input logic                            last
);
  import sitd_pkg::*;

  // output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !char_valid)
    else $error("output beat valid right after reset");

  // a stalled beat stays
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid)
    else $error("output beat dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> $stable(character) && $stable(last))
    else $error("output beat changed while stalled");

  // only a sign or a decimal digit ever leaves
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> character == CHR_MINUS ||
                   (character >= CHR_ZERO && character <= CHR_ZERO + 8'd9))
    else $error("illegal character");

  // the sign always has digits behind it
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    char_valid && character == CHR_MINUS |-> !last)
    else $error("sign marked as last character");

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_ready (char_ready),
  .character  (character),
  .last       (last)
);
